// ===== sv/xte_pkg.sv =====
// xte_pkg: format codes, escaped character codes and entity tables of the text escaper
// depends on nothing; imported by the expander, the output stage, the top level and the testbench
`default_nettype none

package xte_pkg;

    // output format register codes
    localparam logic [1:0] FMT_PLAIN = 2'd0;
    localparam logic [1:0] FMT_XML   = 2'd1;
    localparam logic [1:0] FMT_JSON  = 2'd2;

    // longest escaped sequence (json double quote)
    localparam int MAX_RESULTS = 11;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // characters with special handling
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_AMP  = 8'h26;

    // entity kinds
    localparam logic [2:0] ENT_NONE = 3'd0;
    localparam logic [2:0] ENT_QUOT = 3'd1;
    localparam logic [2:0] ENT_LT   = 3'd2;
    localparam logic [2:0] ENT_GT   = 3'd3;
    localparam logic [2:0] ENT_CR   = 3'd4;
    localparam logic [2:0] ENT_AMP  = 3'd5;

    // length of the json ampersand form minus the ampersand it replaces
    localparam logic [IDX_W-1:0] JSON_AMP_EXTRA = IDX_W'(5);
    localparam logic [IDX_W-1:0] JSON_AMP_LEN   = IDX_W'(6);

    typedef logic [IDX_W-1:0] xte_idx_t;

    // one step of the expansion: a result byte, end marker, or no result at all
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } xte_exp_t;

    function automatic logic [2:0] ent_kind(input logic [7:0] b);
        logic [2:0] k;
        begin
            case (b)
                CH_QUOT: k = ENT_QUOT;
                CH_LT:   k = ENT_LT;
                CH_GT:   k = ENT_GT;
                CH_CR:   k = ENT_CR;
                CH_AMP:  k = ENT_AMP;
                default: k = ENT_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic xte_idx_t ent_len(input logic [2:0] k);
        xte_idx_t n;
        begin
            case (k)
                ENT_QUOT: n = IDX_W'(6);
                ENT_LT:   n = IDX_W'(4);
                ENT_GT:   n = IDX_W'(4);
                ENT_CR:   n = IDX_W'(5);
                ENT_AMP:  n = IDX_W'(5);
                default:  n = IDX_W'(1);
            endcase
            return n;
        end
    endfunction

    // byte at position pos of the xml entity, "&quot;" "&lt;" "&gt;" "&#13;" "&amp;"
    function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] c;
        begin
            c = CH_AMP;
            case (k)
                ENT_QUOT:
                begin
                    case (pos)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = "q";
                        3'd2:    c = "u";
                        3'd3:    c = "o";
                        3'd4:    c = "t";
                        default: c = ";";
                    endcase
                end
                ENT_LT:
                begin
                    case (pos)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = "l";
                        3'd2:    c = "t";
                        default: c = ";";
                    endcase
                end
                ENT_GT:
                begin
                    case (pos)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = "g";
                        3'd2:    c = "t";
                        default: c = ";";
                    endcase
                end
                ENT_CR:
                begin
                    case (pos)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = "#";
                        3'd2:    c = "1";
                        3'd3:    c = "3";
                        default: c = ";";
                    endcase
                end
                ENT_AMP:
                begin
                    case (pos)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = "a";
                        3'd2:    c = "m";
                        3'd3:    c = "p";
                        default: c = ";";
                    endcase
                end
                default: c = CH_AMP;
            endcase
            return c;
        end
    endfunction

    // byte at position pos of the json ampersand form "\u0026"
    function automatic logic [7:0] json_amp_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                3'd0:    c = 8'h5C;
                3'd1:    c = "u";
                3'd2:    c = "0";
                3'd3:    c = "0";
                3'd4:    c = "2";
                default: c = "6";
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/xte_if.sv =====
// xte_in_if and xte_out_if: valid/ready channels for input bytes and escaped result bytes
// standalone, no package needed
`default_nettype none

interface xte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface xte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/xte_expander.sv =====
// xte_expander: picks one byte of the escaped sequence for a held input byte
// depends on xte_pkg for the entity tables and format codes
`default_nettype none

module xte_expander
    import xte_pkg::*;
(
    input  wire logic [7:0] byte_in,
    input  wire logic [1:0] fmt,
    input  wire xte_idx_t   idx,
    output xte_exp_t        exp
);

    logic [2:0] kind;
    xte_idx_t   xml_len;
    xte_idx_t   json_len;
    xte_idx_t   tail_pos;
    logic       escaping;

    assign kind     = ent_kind(byte_in);
    assign xml_len  = ent_len(kind);
    assign json_len = xml_len + JSON_AMP_EXTRA;
    assign tail_pos = idx - JSON_AMP_EXTRA;
    assign escaping = (fmt == FMT_XML) || (fmt == FMT_JSON);

    always_comb
    begin
        exp.data  = byte_in;
        exp.last  = 1'b1;
        exp.empty = 1'b0;
        if (!escaping)
        begin
            exp.data = byte_in;
        end
        else if (byte_in == CH_LF)
        begin
            // newline is dropped
            exp.empty = 1'b1;
        end
        else if (kind == ENT_NONE)
        begin
            exp.data = byte_in;
        end
        else if (fmt == FMT_XML)
        begin
            exp.data = ent_char(kind, idx[2:0]);
            exp.last = (idx == xml_len - IDX_W'(1));
        end
        else
        begin
            // leading ampersand becomes \u0026, entity tail follows
            if (idx < JSON_AMP_LEN)
                exp.data = json_amp_char(idx[2:0]);
            else
                exp.data = ent_char(kind, tail_pos[2:0]);
            exp.last = (idx == json_len - IDX_W'(1));
        end
    end

endmodule

`default_nettype wire

// ===== sv/xte_out_stage.sv =====
// xte_out_stage: output register of the escaper, holds one result until transferred
// depends on xte_pkg and the xte_out_if interface
`default_nettype none

module xte_out_stage
    import xte_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire xte_exp_t exp,
    output logic       can_load,
    xte_out_if.source  out_ch
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    assign can_load       = !out_valid_reg || out_ch.ready;
    assign out_valid_next = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= exp.data;
            out_last_reg <= exp.last;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/xml_json_text_escaper_unit.sv =====
// xml_json_text_escaper_unit: the input register holds a byte, the output register its
// results; throughput: one input byte per cycle when it expands to one result and the
// output does not stall; an escaped byte holds the input register, the byte counter
// stepping its results (up to 11 in json mode); a dropped newline needs no output room
// reset: rst_n async active low clears both valid flags and sets fmt_reg to plain
// depends on xte_pkg, xte_if, xte_expander, xte_out_stage
`default_nettype none

module xml_json_text_escaper_unit
    import xte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_data,
    xte_in_if.sink          in_ch,
    xte_out_if.source       out_ch
);

    // output format register
    logic [1:0] fmt_reg;

    // input register: the byte being expanded, its format and the result index
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic [1:0] hold_fmt_reg;
    xte_idx_t   idx_reg;
    xte_idx_t   idx_next;

    xte_exp_t   exp;
    logic       can_load;
    logic       step;
    logic       finish;
    logic       accept;
    logic       load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_PLAIN;
        else if (cfg_we)
            fmt_reg <= cfg_data;
    end

    // combinational lookup of the current result byte
    xte_expander u_expander
    (
        .byte_in (hold_byte_reg),
        .fmt     (hold_fmt_reg),
        .idx     (idx_reg),
        .exp     (exp)
    );

    // a step emits one byte when the output register has room; a dropped byte needs no room
    assign step   = hold_valid_reg && (exp.empty || can_load);
    assign finish = step && exp.last;
    assign load   = step && !exp.empty;

    // the input register frees up in the same cycle its last byte moves out
    assign in_ch.ready = !hold_valid_reg || finish;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        if (finish)
        begin
            hold_valid_next = 1'b0;
            idx_next        = '0;
        end
        else if (step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            idx_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // payload capture on input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= in_ch.in_byte;
            hold_fmt_reg  <= fmt_reg;
        end
    end

    // result register toward the sink
    xte_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .exp      (exp),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

    // result index stays inside the longest sequence
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (idx_reg < IDX_W'(MAX_RESULTS)))
        else $error("result index past longest sequence");

    // an emitted byte that is not last keeps the input register busy
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !exp.last) |=> (hold_valid_reg && !in_ch.ready || hold_valid_reg))
        else $error("input register released before sequence end");

    // index advances by one per non-final step
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !exp.last) |=> (idx_reg == IDX_W'($past(idx_reg) + IDX_W'(1))))
        else $error("result index did not advance");

    // a new transfer always starts at the first result byte
    a_idx_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (hold_valid_reg && idx_reg == '0))
        else $error("new input byte not started at index zero");

    // format register takes the written value
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (fmt_reg == $past(cfg_data)))
        else $error("format register write lost");

endmodule

`default_nettype wire

// ===== tb/sv/xte_escape_checker.sv =====
`timescale 1ns / 1ps
// xte_escape_checker: works out the escaped byte stream of every input transfer and
// compares it with the result transfers; depends on xte_pkg

module xte_escape_checker
    import xte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    output int         mismatch_count,
    output int         bytes_outstanding
);

    typedef struct {
        logic [7:0] data;
        logic       last;
    } esc_byte_t;

    esc_byte_t  escaped_q[$];
    logic [1:0] fmt_shadow;
    int         errors;

    function automatic void push_escaped(input logic [7:0] c);
        esc_byte_t e;
        e.data = c;
        e.last = 1'b0;
        escaped_q.push_back(e);
    endfunction

    function automatic void expand_byte(input logic [1:0] mode, input logic [7:0] b);
        string     ent;
        string     json_amp;
        int        first;
        esc_byte_t tail;
        json_amp = "\\u0026";
        ent = "";
        first = escaped_q.size();
        if (mode != FMT_XML && mode != FMT_JSON)
        begin
            push_escaped(b);
        end
        else if (b != CH_LF)
        begin
            case (b)
                CH_QUOT: ent = "&quot;";
                CH_LT:   ent = "&lt;";
                CH_GT:   ent = "&gt;";
                CH_CR:   ent = "&#13;";
                CH_AMP:  ent = "&amp;";
                default: ent = "";
            endcase
            if (ent.len() == 0)
            begin
                push_escaped(b);
            end
            else
            begin
                for (int i = 0; i < ent.len(); i++)
                begin
                    // json rewrites the ampersand of the entity
                    if (mode == FMT_JSON && ent[i] == CH_AMP)
                    begin
                        for (int k = 0; k < json_amp.len(); k++)
                        begin
                            push_escaped(json_amp[k]);
                        end
                    end
                    else
                    begin
                        push_escaped(ent[i]);
                    end
                end
            end
        end
        if (escaped_q.size() > first)
        begin
            tail = escaped_q.pop_back();
            tail.last = 1'b1;
            escaped_q.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : compare_proc
        esc_byte_t want;
        if (!rst_n)
        begin
            fmt_shadow = FMT_PLAIN;
            escaped_q.delete();
            errors = 0;
            mismatch_count    <= 0;
            bytes_outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expand_byte(fmt_shadow, in_byte);
            end
            // a new format only applies to later transfers
            if (cfg_we)
            begin
                fmt_shadow = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (escaped_q.size() == 0)
                begin
                    $display("%0t: unexpected result byte %02h last %b",
                             $time, out_byte, out_last);
                    errors++;
                end
                else
                begin
                    want = escaped_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, out_byte);
                        errors++;
                    end
                    if (out_last !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, out_last);
                        errors++;
                    end
                end
            end
            mismatch_count    <= errors;
            bytes_outstanding <= escaped_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: feeds text bytes to xml_json_text_escaper_unit in every output format with
// random gaps on both channels; depends on xte_pkg, xte_if and xte_escape_checker

module testbench;
    import xte_pkg::*;

    // format code with no meaning of its own, behaves as plain
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    localparam int LONG_HOLD        = 300;   // receiver hold-off that backs up the block
    localparam int SETTLE_CYCLES    = 8;     // covers latency and dropped newlines
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no transfer on either channel
    localparam int RANDOM_PHASE_LEN = 27;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;
    int         mismatch_count;
    int         bytes_outstanding;
    int         quiet_cycles = 0;
    bit         tx_idle_on;
    bit         hold_off_go;
    bit         hold_off_done;

    xte_in_if  in_ch();
    xte_out_if out_ch();

    xml_json_text_escaper_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // watches both channels and the format writes, predicts and compares
    xte_escape_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .in_valid          (in_ch.valid),
        .in_ready          (in_ch.ready),
        .in_byte           (in_ch.in_byte),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_byte          (out_ch.out_byte),
        .out_last          (out_ch.last),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial clk = 1'b0;

    always #4 clk = ~clk;

    // idle length: mostly a few cycles, now and then a long pause
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // offer one byte, with an optional gap first, and return at the edge of its transfer
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // stop offering, wait for every predicted byte, then let a dropped newline settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // single register write, only ever issued with the block idle
    task automatic write_format(input logic [1:0] fmt);
        cfg_we   <= 1'b1;
        cfg_data <= fmt;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // random bytes, half of them from the characters that get escaped or dropped
    task automatic random_phase(input logic [1:0] fmt, input bit gappy);
        logic [7:0] b;
        write_format(fmt);
        tx_idle_on = gappy;
        for (int n = 0; n < RANDOM_PHASE_LEN; n++)
        begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       b = CH_QUOT;
                    1:       b = CH_LT;
                    2:       b = CH_GT;
                    3:       b = CH_CR;
                    4:       b = CH_LF;
                    default: b = CH_AMP;
                endcase
            end
            send_byte(b);
        end
        drain_results();
    endtask

    // receiver pacing: calm and jittery stretches, plus one long hold-off on request
    initial
    begin : rx_pacing
        int unsigned stall;
        int unsigned stretch;
        bit          jitter;
        stall         = 0;
        stretch       = 0;
        jitter        = 1'b0;
        hold_off_done = 1'b0;
        out_ch.ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_off_done)
            begin
                // hold-off counted here while the sender keeps offering
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (stretch == 0)
                begin
                    stretch = $urandom_range(20, 60);
                    jitter  = ($urandom_range(0, 2) != 0);
                end
                stretch--;
                if (jitter && $urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    // watchdog: ends the run when neither channel sees a transfer for too long
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = FMT_PLAIN;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        hold_off_go   = 1'b0;
        tx_idle_on    = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain after reset: zero byte, extremes, special characters untouched
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(CH_QUOT);
        send_byte(CH_AMP);
        drain_results();

        // xml: every entity, the dropped newline, ordinary bytes
        write_format(FMT_XML);
        send_byte(CH_QUOT);
        send_byte(CH_LT);
        send_byte(CH_GT);
        send_byte(CH_CR);
        send_byte(CH_AMP);
        send_byte(CH_LF);
        send_byte(8'h80);
        drain_results();

        // json: every entity with the ampersand rewritten, double quote is the longest
        write_format(FMT_JSON);
        send_byte(CH_QUOT);
        send_byte(CH_LT);
        send_byte(CH_GT);
        send_byte(CH_CR);
        send_byte(CH_AMP);
        send_byte(CH_LF);
        send_byte(8'h7F);
        drain_results();

        // unused code behaves as plain, newline included
        write_format(FMT_UNUSED);
        send_byte(CH_QUOT);
        send_byte(CH_LF);
        send_byte(CH_AMP);
        drain_results();

        // first random phase runs back to back against the long receiver hold-off
        hold_off_go = 1'b1;
        random_phase(FMT_JSON, 1'b0);
        random_phase(FMT_XML, $urandom_range(0, 3) != 0);
        random_phase(FMT_PLAIN, $urandom_range(0, 3) != 0);
        random_phase(FMT_UNUSED, $urandom_range(0, 3) != 0);
        random_phase(FMT_JSON, $urandom_range(0, 3) != 0);
        random_phase(FMT_XML, $urandom_range(0, 3) != 0);
        random_phase(FMT_JSON, $urandom_range(0, 3) != 0);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
